@@ rtl/hrfp_pkg.sv @@
// Package for the hex reply frame parser: widths, codes, result word type and helpers.
package hrfp_pkg;

  // Buffer bound, terminator included (valid range 8..31)
  localparam int unsigned MAX_FRAME_BYTES = 16;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned NUM_NIBBLES     = 6;
  localparam int unsigned SLOT_W          = $clog2(NUM_NIBBLES);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);
  // Digit count reported for an overlong frame, saturated at 15
  localparam logic [3:0] TOO_LONG_COUNT =
    (MAX_FRAME_BYTES - 1 > 15) ? 4'd15 : 4'(MAX_FRAME_BYTES - 1);

  localparam logic [7:0] HDR_ACCEPT = 8'h3D;  // '='
  localparam logic [7:0] HDR_FAILED = 8'h21;  // '!'
  localparam logic [7:0] TERM_RESET = 8'h0D;  // carriage return

  // Configuration register indexes
  localparam logic REG_TERMINATOR = 1'b0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FAILED     = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_DIGIT  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] value;
    logic [3:0]  count;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  // Uppercase hex digit decode; anything else is flagged and reads as zero
  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.ok  = 1'b0;
    d.nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.ok  = 1'b1;
      d.nib = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.ok  = 1'b1;
      d.nib = 4'(b - 8'h37);
    end
    return d;
  endfunction

endpackage

@@ rtl/hex_reply_frame_parser_core.sv @@
// Top level: reply frame parser with APB terminator register and skid-buffered result.
//
// Usage:
//   Input channel (in_valid/in_stall/in_rx_byte) takes one received byte per
//   word. Bytes are collected into a frame; the first is the header, the rest
//   payload hex digits. The byte equal to the terminator register ends the
//   frame and yields one result word (status, digit count, 24-bit value).
//   A frame that reaches MAX_FRAME_BYTES bytes without a terminator yields a
//   too-long result on the byte that would overflow, and that byte is dropped.
//   A result is registered in the result register (after the skid stage while the receiver stalls) before out_*.
//   Throughput: one byte per cycle while in_stall is low, set by the single-stage parse logic.
//   Receiver stall: the result register holds its word; a second result goes
//   into a one-word skid stage, and only while that stage is full is in_stall
//   raised, so input keeps flowing while one result waits.
//   Reset (rst_n low, synchronous): frame state cleared, terminator back to
//   carriage return, both output words emptied.
//   Config: write the terminator at byte address 0 only while idle.
module hex_reply_frame_parser_core
  import hrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_frame_status,
  output logic [23:0] out_decoded_value,
  output logic [3:0]  out_digit_count,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Registers
  logic [7:0]       term_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [3:0]       nib_r   [NUM_NIBBLES];
  logic [3:0]       nib_nxt [NUM_NIBBLES];
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  result_t          skid_r, skid_nxt;

  logic             accept;
  logic             is_term;
  logic             too_long;
  logic             emit;
  result_t          res;
  hex_digit_t       dig;
  logic [POS_W-1:0] slot;
  logic             load_out;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TERMINATOR) ? {24'd0, term_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= TERM_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_TERMINATOR) begin
      term_r <= cfg_pwdata[7:0];
    end
  end

  // Handshakes
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign load_out  = !out_valid_r || !out_stall;

  // Parse one byte
  assign is_term  = (in_rx_byte == term_r);
  assign too_long = !is_term && (pos_r >= POS_LAST);
  assign emit     = accept && (is_term || too_long);
  assign dig      = hex_decode(in_rx_byte);
  assign slot     = pos_r - POS_W'(1);

  always_comb begin
    res.status = ST_BAD_HEADER;
    res.value  = 24'd0;
    res.count  = 4'd0;
    if (too_long) begin
      res.status = ST_TOO_LONG;
      res.count  = TOO_LONG_COUNT;
    end else if (pos_r != '0) begin
      res.count = (slot > POS_W'(15)) ? 4'd15 : 4'(slot);
      if (hdr_r == HDR_ACCEPT) begin
        res.status = bad_r ? ST_BAD_DIGIT : ST_OK;
      end else if (hdr_r == HDR_FAILED) begin
        res.status = ST_FAILED;
      end
    end
    // byte-swapped digit order d4 d5 d2 d3 d0 d1
    if (res.status == ST_OK) begin
      res.value = {nib_r[4], nib_r[5], nib_r[2], nib_r[3], nib_r[0], nib_r[1]};
    end
  end

  // Frame state next values
  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    bad_nxt = bad_r;
    for (int k = 0; k < NUM_NIBBLES; k++) begin
      nib_nxt[k] = nib_r[k];
    end
    if (accept) begin
      if (is_term || too_long) begin
        pos_nxt = '0;
        hdr_nxt = 8'd0;
        bad_nxt = 1'b0;
        for (int k = 0; k < NUM_NIBBLES; k++) begin
          nib_nxt[k] = 4'd0;
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == '0) begin
          hdr_nxt = in_rx_byte;
        end else begin
          if (!dig.ok) begin
            bad_nxt = 1'b1;
          end
          for (int k = 0; k < NUM_NIBBLES; k++) begin
            if (slot == POS_W'(k)) begin
              nib_nxt[k] = dig.nib;
            end
          end
        end
      end
    end
  end

  // Result register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (load_out) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = emit;
        if (emit) begin
          out_nxt = res;
        end
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      hdr_r        <= 8'd0;
      bad_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int k = 0; k < NUM_NIBBLES; k++) begin
        nib_r[k] <= 4'd0;
      end
    end else begin
      pos_r        <= pos_nxt;
      hdr_r        <= hdr_nxt;
      bad_r        <= bad_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      for (int k = 0; k < NUM_NIBBLES; k++) begin
        nib_r[k] <= nib_nxt[k];
      end
    end
  end

  // Payload words need no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_frame_status  = out_r.status;
  assign out_decoded_value = out_r.value;
  assign out_digit_count   = out_r.count;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while result register empty");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("frame position beyond buffer bound");

  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.value == 24'd0)
    else $error("nonzero value on a failed frame");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> pos_r == '0 && !bad_r)
    else $error("frame state not cleared after result");

endmodule

@@ tb/hex_reply_frame_parser_core_tb.sv @@
// Testbench for the hex reply frame parser: random byte streams checked against a frame predictor.
module hex_reply_frame_parser_core_tb
  import hrfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CH_LOWER_G = 8'h67;  // 'g'
  localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] TERM_MIN   = 8'h00;
  localparam logic [7:0] TERM_MAX   = 8'hFF;
  localparam int         LONG_HOLD  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_frame_status;
  logic [23:0] out_decoded_value;
  logic [3:0]  out_digit_count;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hex_reply_frame_parser_core DUT (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bytes waiting to be sent and replies waiting to be seen
  logic [7:0] rx_stream[$];
  result_t    pending_replies[$];

  // Predictor state
  logic [7:0] term_char = TERM_RESET;
  int         frame_len = 0;
  logic [7:0] hdr_byte = '0;
  logic [3:0] nibs[NUM_NIBBLES];
  bit         bad_seen = 1'b0;

  // Run control and bookkeeping
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int words_in = 0;
  int replies_out = 0;
  int status_seen[5] = '{default: 0};

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_frame();
    frame_len = 0;
    hdr_byte  = '0;
    bad_seen  = 1'b0;
    foreach (nibs[k]) nibs[k] = '0;
  endtask

  // Advance the frame predictor by one received byte
  task automatic parse_rx_byte(input logic [7:0] b);
    result_t    r;
    logic [3:0] nib;
    bit         ended;
    r     = '0;
    ended = 1'b0;
    if (b == term_char) begin
      ended = 1'b1;
      if (frame_len == 0) begin
        r.status = ST_BAD_HEADER;
        r.count  = '0;
      end else begin
        r.count = (frame_len - 1 > 15) ? 4'd15 : 4'(frame_len - 1);
        if (hdr_byte == HDR_ACCEPT) r.status = bad_seen ? ST_BAD_DIGIT : ST_OK;
        else if (hdr_byte == HDR_FAILED) r.status = ST_FAILED;
        else r.status = ST_BAD_HEADER;
      end
      // byte-swapped digit order d4 d5 d2 d3 d0 d1
      if (r.status == ST_OK)
        r.value = {nibs[4], nibs[5], nibs[2], nibs[3], nibs[0], nibs[1]};
    end else if (frame_len >= MAX_FRAME_BYTES - 1) begin
      ended    = 1'b1;
      r.status = ST_TOO_LONG;
      r.count  = (MAX_FRAME_BYTES - 1 > 15) ? 4'd15 : 4'(MAX_FRAME_BYTES - 1);
    end else begin
      if (frame_len == 0) begin
        hdr_byte = b;
      end else begin
        nib = '0;
        if (b >= CH_ZERO && b <= CH_NINE) nib = 4'(b - CH_ZERO);
        else if (b >= CH_UPPER_A && b <= CH_UPPER_F) nib = 4'(b - CH_UPPER_A + 10);
        else bad_seen = 1'b1;
        if (frame_len - 1 < NUM_NIBBLES) nibs[frame_len - 1] = nib;
      end
      frame_len++;
    end
    if (ended) begin
      pending_replies.push_back(r);
      clear_frame();
    end
  endtask

  // Driver: when the current word is taken or none is up, offer the next byte, with random gaps unless steady
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_stream.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          in_rx_byte <= rx_stream.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left <= LONG_HOLD;
      hold_ack  <= hold_req;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted reply word and pick the next stall
  always @(posedge clk) begin : monitor
    result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_out++;
        if (out_frame_status < 3'd5) status_seen[out_frame_status]++;
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply status %0d value %06h count %0d",
                                    out_frame_status, out_decoded_value, out_digit_count));
        end else begin
          exp_r = pending_replies.pop_front();
          if (out_frame_status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d (%s)", out_frame_status,
                                      exp_r.status, exp_r.status.name()));
          if (out_decoded_value !== exp_r.value)
            report_mismatch($sformatf("value %06h, expected %06h", out_decoded_value,
                                      exp_r.value));
          if (out_digit_count !== exp_r.count)
            report_mismatch($sformatf("digit count %0d, expected %0d", out_digit_count,
                                      exp_r.count));
        end
      end
      out_stall <= (hold_left > 1) || (!steady && $urandom_range(0, 99) < 25);
    end
  end

  // Register write over the config port, two-phase
  task automatic write_terminator(input logic [7:0] t);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TERMINATOR, 2'b00};
    cfg_pwdata  <= {24'd0, t};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    term_char = t;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_stream.size() != 0 || in_valid || pending_replies.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int k);
    return (k < 10) ? CH_ZERO + 8'(k) : CH_UPPER_A + 8'(k - 10);
  endfunction

  // One mostly well-formed frame; now and then noise or a missing terminator
  task automatic queue_random_frame(inout int pushed);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) begin
        rx_stream.push_back(8'($urandom_range(0, 255)));
        pushed++;
      end
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70) rx_stream.push_back(HDR_ACCEPT);
    else if (r < 82) rx_stream.push_back(HDR_FAILED);
    else rx_stream.push_back(8'($urandom_range(0, 255)));
    pushed++;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 18) : $urandom_range(0, 8);
    repeat (len) begin
      if ($urandom_range(0, 9) != 0) rx_stream.push_back(hex_char($urandom_range(0, 15)));
      else rx_stream.push_back(8'($urandom_range(0, 255)));
      pushed++;
    end
    if ($urandom_range(0, 19) != 0) begin
      rx_stream.push_back(term_char);
      pushed++;
    end
  endtask

  // One phase of random frames under a given terminator
  task automatic run_phase(input bit do_write, input logic [7:0] t, input int n_bytes,
                           input bit no_gaps, input bit long_hold);
    int pushed;
    pushed = 0;
    if (do_write) write_terminator(t);
    @(negedge clk);
    steady = no_gaps;
    while (pushed < n_bytes) queue_random_frame(pushed);
    if (long_hold) hold_req = !hold_req;
    wait_drained();
  endtask

  task automatic push_bytes(input logic [7:0] bytes[]);
    foreach (bytes[k]) rx_stream.push_back(bytes[k]);
  endtask

  // Main sequence
  initial begin
    clear_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset terminator
    push_bytes('{TERM_RESET});                                      // empty frame
    push_bytes('{HDR_ACCEPT, "F", "E", "D", "C", "B", "A", TERM_RESET});
    push_bytes('{HDR_ACCEPT, CH_ZERO, CH_NINE, TERM_RESET});         // short, rest zero
    push_bytes('{HDR_FAILED, CH_LOWER_G, TERM_RESET});               // header wins
    push_bytes('{CH_LOWER_X, 8'h00, TERM_RESET});                    // bad header
    push_bytes('{HDR_ACCEPT, 8'h00, TERM_RESET});                    // NUL digit
    rx_stream.push_back(HDR_ACCEPT);                                 // overlong frame
    repeat (MAX_FRAME_BYTES - 1) rx_stream.push_back(CH_NINE);
    wait_drained();

    run_phase(1'b0, TERM_RESET, 330, 1'b0, 1'b0);
    run_phase(1'b1, TERM_MAX, 200, 1'b1, 1'b0);     // no idling on either side
    run_phase(1'b1, TERM_MIN, 200, 1'b0, 1'b0);
    run_phase(1'b1, HDR_ACCEPT, 150, 1'b0, 1'b0);   // terminator equals header
    run_phase(1'b1, CH_UPPER_A, 150, 1'b0, 1'b0);   // terminator equals a digit
    run_phase(1'b1, TERM_RESET, 450, 1'b1, 1'b1);   // receiver holds off, input backs up

    repeat (5) @(posedge clk);
    $display("Ran %0d input words into %0d reply frames under terminators 0D FF 00 3D 41,",
             words_in, replies_out);
    $display("status ok %0d, failed %0d, bad header %0d, bad digit %0d, too long %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("Timeout waiting for the reply stream to drain");
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hrfp_pkg.sv
rtl/hex_reply_frame_parser_core.sv
tb/hex_reply_frame_parser_core_tb.sv
